// ----- src/hfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types, constants and helpers for the hex float / binary single
// precision word converter.
// ----------------------------------------------------------------------------
package hfc_pkg;

    // Direction register codes
    localparam logic DIR_HEX_TO_BIN = 1'b0;
    localparam logic DIR_BIN_TO_HEX = 1'b1;

    // Binary single precision result when the hex exponent saturates high
    localparam logic [7:0]  BIN_MAX_EXP  = 8'hFE;
    localparam logic [22:0] BIN_MAX_FRAC = 23'h7FFFFF;

    // Biased binary exponent limits, kept in a 10-bit signed form
    localparam logic signed [9:0] BIN_EXP_LIMIT = 10'sd254;
    localparam logic signed [9:0] HEX_REBIAS    = 10'sd130;

    // Offset added to k to form the excess-64 hex exponent
    localparam logic [9:0] HEX_EXP_BIAS = 10'd32;

    // Input word
    typedef struct packed {
        logic [31:0] source_word;
        logic        end_of_block;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [31:0] converted_word;
        logic        end_of_block_out;
    } out_word_t;

    // Prepared operands between the front and back halves
    typedef struct packed {
        logic        dir;
        logic        sign;
        logic        zero;
        logic [23:0] mant;
        logic [4:0]  shamt;
        logic [9:0]  expo;
        logic        eob;
    } prep_t;

    // Count leading zeros of a 24-bit fraction (nonzero input)
    function automatic logic [4:0] lead_zeros(input logic [23:0] frac);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (frac[i]) begin
                lz = 5'(23 - i);
            end
        end
        return lz;
    endfunction

endpackage

// ----- src/hex_float_single_convert_core.sv -----
// ----------------------------------------------------------------------------
// hex_float_single_convert_core
// Streaming converter between base-16 hex float and binary single precision.
// ----------------------------------------------------------------------------
// The core takes one 32-bit word per cycle and returns it converted after
// three register stages (input register, operand preparation, output
// register); throughput is one word per cycle when m_ready stays high.
// The leading-zero count and the normalizing shift set the depth of the
// preparation and output stages. The direction register (0: hex to
// binary, 1: binary to hex) is sampled with each word as it enters and
// should only be written while no words are in flight.
module hex_float_single_convert_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  hfc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hfc_pkg::out_word_t m_data
);

    logic           direction_reg;
    logic           direction_next;
    logic           prep_valid;
    logic           prep_ready;
    hfc_pkg::prep_t prep_data;

    // Direction register
    assign direction_next = cfg_wr_en ? cfg_wr_data : direction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= hfc_pkg::DIR_HEX_TO_BIN;
        end else begin
            direction_reg <= direction_next;
        end
    end

    hfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dir        (direction_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .prep_valid (prep_valid),
        .prep_ready (prep_ready),
        .prep_data  (prep_data)
    );

    hfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prep_valid (prep_valid),
        .prep_ready (prep_ready),
        .prep_data  (prep_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- src/hfc_front.sv -----
// ----------------------------------------------------------------------------
// hfc_front
// Input register plus operand preparation stage: leading-zero count and
// exponent rebias for hex words, alignment shift and exponent for binary.
// ----------------------------------------------------------------------------
module hfc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               dir,
    input  logic               s_valid,
    output logic               s_ready,
    input  hfc_pkg::in_word_t  s_data,
    output logic               prep_valid,
    input  logic               prep_ready,
    output hfc_pkg::prep_t     prep_data
);

    logic              a_valid_reg;
    logic              a_valid_next;
    hfc_pkg::in_word_t a_word_reg;
    logic              a_dir_reg;
    logic              a_ready;

    logic              b_valid_reg;
    logic              b_valid_next;
    hfc_pkg::prep_t    b_reg;
    hfc_pkg::prep_t    b_next;
    logic              b_ready;

    logic [31:0]       w;
    logic [23:0]       frac;
    logic [4:0]        lz;
    logic [9:0]        e10;
    logic [1:0]        e_low;

    // Stage handshakes: a stage takes a word when empty or draining
    assign b_ready = !b_valid_reg || prep_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    assign a_valid_next = a_ready ? s_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // Prepare operands from the held input word
    always_comb begin
        w     = a_word_reg.source_word;
        frac  = w[23:0];
        lz    = hfc_pkg::lead_zeros(frac);
        e10   = {2'b00, w[30:23]} + 10'd5;
        e_low = w[24:23] + 2'd2;

        b_next.dir   = a_dir_reg;
        b_next.sign  = w[31];
        b_next.eob   = a_word_reg.end_of_block;
        if (a_dir_reg == hfc_pkg::DIR_BIN_TO_HEX) begin
            b_next.zero  = (w[30:23] == 8'd0);
            b_next.mant  = {1'b1, w[22:0]};
            b_next.shamt = {3'b000, 2'd0 - e_low};
            b_next.expo  = {2'b00, e10[9:2]} + hfc_pkg::HEX_EXP_BIAS;
        end else begin
            b_next.zero  = (frac == 24'd0);
            b_next.mant  = frac;
            b_next.shamt = lz;
            b_next.expo  = 10'($signed({1'b0, w[30:24], 2'b00})
                               - hfc_pkg::HEX_REBIAS
                               - $signed({5'b00000, lz}));
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload registers: load on advance, hold on stall
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_word_reg <= s_data;
            a_dir_reg  <= dir;
        end
        if (b_ready) begin
            b_reg <= b_next;
        end
    end

    assign prep_valid = b_valid_reg;
    assign prep_data  = b_reg;

endmodule

// ----- src/hfc_back.sv -----
// ----------------------------------------------------------------------------
// hfc_back
// Shift and assembly stage: normalizes or aligns the mantissa, applies
// saturation and flush rules, and holds the result in the output register.
// ----------------------------------------------------------------------------
module hfc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               prep_valid,
    output logic               prep_ready,
    input  hfc_pkg::prep_t     prep_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hfc_pkg::out_word_t m_data
);

    logic                c_valid_reg;
    logic                c_valid_next;
    hfc_pkg::out_word_t  c_reg;
    hfc_pkg::out_word_t  c_next;

    logic [23:0]         norm;
    logic [23:0]         aligned;
    logic signed [9:0]   bexp;

    assign prep_ready   = !c_valid_reg || m_ready;
    assign c_valid_next = prep_ready ? prep_valid : c_valid_reg;

    // Assemble the converted word
    always_comb begin
        norm    = prep_data.mant << prep_data.shamt;
        aligned = prep_data.mant >> prep_data.shamt[1:0];
        bexp    = $signed(prep_data.expo);

        c_next.end_of_block_out = prep_data.eob;
        if (prep_data.zero) begin
            c_next.converted_word = 32'd0;
        end else if (prep_data.dir == hfc_pkg::DIR_BIN_TO_HEX) begin
            c_next.converted_word = {prep_data.sign, prep_data.expo[6:0], aligned};
        end else if (bexp > hfc_pkg::BIN_EXP_LIMIT) begin
            c_next.converted_word = {prep_data.sign, hfc_pkg::BIN_MAX_EXP,
                                     hfc_pkg::BIN_MAX_FRAC};
        end else if (bexp <= 10'sd0) begin
            c_next.converted_word = 32'd0;
        end else begin
            c_next.converted_word = {prep_data.sign, prep_data.expo[7:0], norm[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (prep_ready) begin
            c_reg <= c_next;
        end
    end

    assign m_valid = c_valid_reg;
    assign m_data  = c_reg;

endmodule

// ----- test/tb_hex_float_single_convert_core.sv -----
// ----------------------------------------------------------------------------
// tb_hex_float_single_convert_core
// Self-checking testbench for the hex float / binary single converter core.
// Words go in over a valid/ready stream. The testbench predicts each converted
// word and compares it field by field with what comes out. The run starts with
// directed corner words in both directions. Random phases follow, with the
// direction changed between them. It then fills the pipeline behind a long
// output stall, pauses for a full drain and ends with a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_hex_float_single_convert_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    hfc_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    hfc_pkg::out_word_t m_data;

    // Conversion direction as the testbench believes it is set
    logic       conv_dir;

    // Converted words still owed by the core, oldest first
    hfc_pkg::out_word_t due_words[$];

    bit         src_gaps_on;
    bit         sink_stalls_on;
    int         long_hold_cycles;
    int         cycle_count;
    int         error_count;
    int         words_sent;
    int         words_checked;
    int         dir_writes;

    hex_float_single_convert_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Clock: 10 ns period
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hex float to binary single: normalize, rebias, saturate or flush
    function automatic logic [31:0] hfp_to_single(input logic [31:0] w);
        logic [23:0] frac;
        int          ex;
        frac = w[23:0];
        if (frac == 24'd0) begin
            return 32'd0;
        end
        ex = 4 * int'(w[30:24]) - 256;
        while (!frac[23]) begin
            frac = frac << 1;
            ex--;
        end
        if (ex > 128) begin
            return {w[31], hfc_pkg::BIN_MAX_EXP, hfc_pkg::BIN_MAX_FRAC};
        end
        if (ex <= -126) begin
            return 32'd0;
        end
        return {w[31], 8'(ex + 126), frac[22:0]};
    endfunction

    // Binary single to hex float: align exponent to a multiple of four, truncate
    function automatic logic [31:0] single_to_hfp(input logic [31:0] w);
        logic [8:0]  e;
        logic [23:0] mant;
        int          k;
        if (w[30:23] == 8'd0) begin
            return 32'd0;
        end
        e    = w[30:23] + 9'd2;
        mant = {1'b1, w[22:0]};
        k    = (int'(e) + 3) >> 2;
        mant = mant >> ((4 * k - int'(e)) & 3);
        return {w[31], 7'(k + 32), mant};
    endfunction

    function automatic hfc_pkg::out_word_t predict_word(input hfc_pkg::in_word_t item,
                                                        input logic d);
        hfc_pkg::out_word_t r;
        r.converted_word   = (d == hfc_pkg::DIR_BIN_TO_HEX)
                             ? single_to_hfp(item.source_word)
                             : hfp_to_single(item.source_word);
        r.end_of_block_out = item.end_of_block;
        return r;
    endfunction

    // Random source word, biased toward the interesting regions of each format
    function automatic logic [31:0] gen_source_word(input logic d);
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 3))
            1: begin
                // leading zeros in the fraction
                w[23:0] = w[23:0] >> $urandom_range(0, 23);
            end
            2: begin
                if (d == hfc_pkg::DIR_HEX_TO_BIN) begin
                    // exponents near underflow and overflow
                    w[30:24] = $urandom_range(0, 1) ? 7'($urandom_range(28, 36))
                                                    : 7'($urandom_range(94, 98));
                    w[23:0]  = w[23:0] >> $urandom_range(0, 7);
                end else begin
                    // zero, smallest, largest and Inf/NaN exponents
                    w[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                                    : 8'($urandom_range(254, 255));
                end
            end
            3: begin
                // sparse fraction
                w[22:0] = w[22:0] & 23'($urandom);
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // Offer one word, hold it until accepted, then record its prediction
    task automatic send_word(input logic [31:0] w, input logic eob);
        hfc_pkg::in_word_t item;
        item = '{source_word: w, end_of_block: eob};
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_words.push_back(predict_word(item, conv_dir));
        words_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(gen_source_word(conv_dir), $urandom_range(0, 7) == 0);
        s_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (due_words.size() != 0) @(posedge aclk);
    endtask

    // Write the direction register; caller makes sure the core is idle
    task automatic set_direction(input logic d);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        conv_dir = d;
        dir_writes++;
    endtask

    task automatic test_hex_to_bin_corners();
        set_direction(hfc_pkg::DIR_HEX_TO_BIN);
        send_word(32'h0000_0000, 1'b0);   // zero
        send_word(32'hFF00_0000, 1'b1);   // zero fraction, sign and exponent set
        send_word(32'h8000_0000, 1'b0);   // negative zero
        send_word(32'h4110_0000, 1'b0);   // one, needs normalization
        send_word(32'h7FFF_FFFF, 1'b1);   // overflow, positive
        send_word(32'hFFFF_FFFF, 1'b0);   // overflow, negative
        send_word(32'h6080_0000, 1'b0);   // largest exponent without overflow
        send_word(32'h6180_0000, 1'b0);   // just past overflow
        send_word(32'h6100_0001, 1'b1);   // long normalizing shift
        send_word(32'h0000_0001, 1'b0);   // underflow
        send_word(32'h8000_0001, 1'b0);   // underflow drops the sign
        send_word(32'h2140_0000, 1'b0);   // smallest normal result
        send_word(32'hA120_0000, 1'b1);   // one step below, flushed
        s_valid <= 1'b0;
    endtask

    task automatic test_bin_to_hex_corners();
        wait_for_results();
        set_direction(hfc_pkg::DIR_BIN_TO_HEX);
        send_word(32'h0000_0000, 1'b0);   // zero
        send_word(32'h807F_FFFF, 1'b1);   // subnormal, sign dropped
        send_word(32'h0080_0000, 1'b0);   // smallest normal
        send_word(32'h3F80_0000, 1'b0);   // one
        send_word(32'h4000_0000, 1'b0);   // alignment shifts of one and two bits
        send_word(32'h4040_0000, 1'b1);
        send_word(32'h4080_0000, 1'b0);
        send_word(32'h40FF_FFFF, 1'b0);
        send_word(32'h7F7F_FFFF, 1'b0);   // largest finite
        send_word(32'h7F80_0000, 1'b1);   // infinity as a number
        send_word(32'hFFFF_FFFF, 1'b0);   // NaN as a number
        s_valid <= 1'b0;
    endtask

    // Random phases, direction changed in between, idling varied per phase
    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            wait_for_results();
            set_direction((ph % 2 == 0) ? hfc_pkg::DIR_HEX_TO_BIN
                                        : hfc_pkg::DIR_BIN_TO_HEX);
            src_gaps_on    = (ph != 2);
            sink_stalls_on = (ph != 3);
            send_random(60);
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Hold the output off for a long stretch while words keep coming
    task automatic test_output_backpressure();
        wait_for_results();
        set_direction(hfc_pkg::DIR_HEX_TO_BIN);
        src_gaps_on      = 1'b0;
        long_hold_cycles = HOLD_CYCLES;
        send_random(40);
        src_gaps_on = 1'b1;
    endtask

    // Stop sending until the pipeline has fully drained, then resume
    task automatic test_drain_pause();
        wait_for_results();
        set_direction(hfc_pkg::DIR_BIN_TO_HEX);
        send_random(30);
        wait_for_results();
        send_random(30);
    endtask

    // Full rate in both directions, no idling on either side
    task automatic test_full_rate();
        wait_for_results();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_direction(hfc_pkg::DIR_HEX_TO_BIN);
        send_random(40);
        wait_for_results();
        set_direction(hfc_pkg::DIR_BIN_TO_HEX);
        send_random(40);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : ready_driver
        int n;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_cycles > 0) begin
                n = long_hold_cycles;
                long_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each delivered word with the oldest prediction
    always @(posedge aclk) begin : result_check
        hfc_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                         m_data.converted_word, m_data.end_of_block_out);
                error_count++;
            end else begin
                want = due_words.pop_front();
                words_checked++;
                if (m_data.converted_word !== want.converted_word) begin
                    $display("%0t: converted_word expected %h actual %h", $time,
                             want.converted_word, m_data.converted_word);
                    error_count++;
                end
                if (m_data.end_of_block_out !== want.end_of_block_out) begin
                    $display("%0t: end_of_block_out expected %b actual %b", $time,
                             want.end_of_block_out, m_data.end_of_block_out);
                    error_count++;
                end
            end
        end
    end

    // Cycle counter and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d words outstanding", $time, due_words.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : main
        cycle_count      = 0;
        error_count      = 0;
        words_sent       = 0;
        words_checked    = 0;
        dir_writes       = 0;
        long_hold_cycles = 0;
        src_gaps_on      = 1'b1;
        sink_stalls_on   = 1'b1;
        conv_dir         = hfc_pkg::DIR_HEX_TO_BIN;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;

        // Hold reset, then release
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_hex_to_bin_corners();
        test_bin_to_hex_corners();
        test_random_phases();
        test_output_backpressure();
        test_drain_pause();
        test_full_rate();

        // Drain and let the pipeline settle
        wait_for_results();
        repeat (PIPE_LATENCY + 5) @(posedge aclk);
        if (due_words.size() != 0) begin
            error_count++;
        end

        $display("Converted %0d words in both directions over %0d direction writes,",
                 words_checked, dir_writes);
        $display("including corner words, random idling, a long output stall and full rate.");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
